// File: design/assert_macros.svh
// Assertion macros for the allocator RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// plain invariant
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`endif

// File: design/mfva_pkg.sv
// Types, constants and key tables of the MIDI FM voice allocator.
// No dependencies.
package mfva_pkg;

  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;

  localparam logic [1:0] CFG_DRUM_CHANNEL   = 2'd0;
  localparam logic [1:0] CFG_DRUM_KEY_LOW   = 2'd1;
  localparam logic [1:0] CFG_DRUM_KEY_HIGH  = 2'd2;
  localparam logic [1:0] CFG_DRUM_PITCH_KEY = 2'd3;

  localparam logic [7:0] REG_FLOW   = 8'hA0;
  localparam logic [7:0] REG_FHIGH  = 8'hB0;
  localparam logic [7:0] KEY_ON_BIT = 8'h20;
  localparam logic [7:0] HIGH_MASK  = 8'h3F;

  localparam int OQ_DEPTH = 4;

  localparam logic [9:0] FNUM_LOW [30] = '{
    10'd182, 10'd192, 10'd204, 10'd216, 10'd229, 10'd242, 10'd257, 10'd272,
    10'd288, 10'd306, 10'd324, 10'd343, 10'd363, 10'd385, 10'd408, 10'd432,
    10'd458, 10'd485, 10'd514, 10'd544, 10'd577, 10'd611, 10'd647, 10'd686,
    10'd727, 10'd770, 10'd816, 10'd864, 10'd915, 10'd970
  };

  typedef enum logic [1:0] {OP_NONE, OP_ON, OP_REL, OP_OFF} op_kind_e;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPLY, S_EMIT_LO, S_EMIT_HI, S_FLUSH
  } seq_state_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [3:0]  ch;
    logic [6:0]  key;
    logic        sound;
    logic [6:0]  pitch;
    logic [31:0] age;
  } op_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] val;
    logic       last;
  } wr_t;

  typedef struct packed {
    logic       stall;
    logic [2:0] ocount;
  } back_status_t;

  // clamped frequency number; keys 30..113 repeat the last octave of the low table
  function automatic logic [9:0] key_fnum(input logic [6:0] key);
    logic [6:0] r;
    r = 7'(key - 7'd30);
    if (key < 7'd30) return FNUM_LOW[key[4:0]];
    if (key >= 7'd114) return 10'd1023;
    for (int j = 0; j < 6; j++) begin
      if (r >= 7'd12) r = 7'(r - 7'd12);
    end
    return FNUM_LOW[5'(r + 7'd18)];
  endfunction

  function automatic logic [2:0] key_block(input logic [6:0] key);
    logic [6:0] k;
    logic [2:0] b;
    k = 7'(key - 7'd30);
    b = 3'd1;
    if (key < 7'd30) return 3'd0;
    for (int j = 1; j < 7; j++) begin
      if (k >= 7'(12 * j)) b = 3'(j + 1);
    end
    return b;
  endfunction

endpackage

// File: design/midi_fm_voice_allocator.sv
// MIDI FM voice allocator. A sounding note-on takes the back end through pop, a serial
// scan over the voices, apply, two write steps and flush; when nothing sounds, the write
// steps are skipped. Note-off and release also scan the voices serially, a release
// stopping at its first active match, then flush; other events are only popped.
// Two-entry op queue in front; a full four-entry result queue stalls the back end.
// Reset (async, active low) clears all voice state, shadows, counter and queues.
module midi_fm_voice_allocator #(
  parameter int VOICE_COUNT = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] cmd_i,
  input  logic [3:0] midi_channel_i,
  input  logic [6:0] note_key_i,
  input  logic [6:0] velocity_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] reg_index_o,
  output logic [7:0] reg_value_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);
`include "assert_macros.svh"

  logic                   op_valid, op_pop;
  mfva_pkg::op_t          op;
  mfva_pkg::back_status_t status;

  assign cfg_ready_o = 1'b1;

  mfva_front u_front (
    .clk_i, .rst_ni, .push, .full, .cmd_i, .midi_channel_i, .note_key_i,
    .velocity_i, .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .op_valid_o(op_valid), .op_o(op), .op_pop_i(op_pop)
  );

  mfva_back #(.VOICE_COUNT(VOICE_COUNT)) u_back (
    .clk_i, .rst_ni, .op_valid_i(op_valid), .op_i(op), .op_pop_o(op_pop),
    .pop, .empty, .reg_index_o, .reg_value_o, .last_o, .status_o(status)
  );

  `ASSERT_ALWAYS(a_oq_bound, clk_i, rst_ni, status.ocount <= 3'(mfva_pkg::OQ_DEPTH))
  `ASSERT_IMPL(a_stall_full, clk_i, rst_ni, status.stall, status.ocount == 3'(mfva_pkg::OQ_DEPTH))

endmodule

// File: design/mfva_front.sv
// Front end: config registers, event counter, event classification, op queue.
// Depends on mfva_pkg.
module mfva_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         cmd_i,
  input  logic [3:0]         midi_channel_i,
  input  logic [6:0]         note_key_i,
  input  logic [6:0]         velocity_i,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  output logic               op_valid_o,
  output mfva_pkg::op_t      op_o,
  input  logic               op_pop_i
);

  logic [3:0]  drum_ch_q;
  logic [6:0]  drum_lo_q, drum_hi_q, drum_pitch_q;
  logic [31:0] cnt_q, cnt_d;
  mfva_pkg::op_t q_q [2];
  mfva_pkg::op_t op_new;
  logic        wr_q, rd_q;
  logic [1:0]  fill_q, fill_d;
  logic        acc;

  assign full = (fill_q == 2'd2);
  assign acc  = push && !full;
  assign op_valid_o = (fill_q != 2'd0);
  assign op_o = q_q[rd_q];

  always_comb begin
    cnt_d = acc ? cnt_q + 32'd1 : cnt_q;
    op_new.ch    = midi_channel_i;
    op_new.key   = note_key_i;
    op_new.age   = cnt_q + 32'd1;
    op_new.sound = 1'b1;
    op_new.pitch = note_key_i;
    if (midi_channel_i == drum_ch_q) begin
      op_new.pitch = drum_pitch_q;
      op_new.sound = (note_key_i >= drum_lo_q) && (note_key_i <= drum_hi_q);
    end
    priority if (cmd_i == mfva_pkg::CMD_NOTE_ON) begin
      op_new.kind = (velocity_i == 7'd0) ? mfva_pkg::OP_REL : mfva_pkg::OP_ON;
    end else if (cmd_i == mfva_pkg::CMD_NOTE_OFF) begin
      op_new.kind = mfva_pkg::OP_OFF;
    end else begin
      op_new.kind = mfva_pkg::OP_NONE;
    end
    fill_d = fill_q + {1'b0, acc} - {1'b0, op_pop_i && op_valid_o};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drum_ch_q    <= 4'd9;
      drum_lo_q    <= 7'd35;
      drum_hi_q    <= 7'd75;
      drum_pitch_q <= 7'd35;
      cnt_q        <= 32'd0;
      wr_q         <= 1'b0;
      rd_q         <= 1'b0;
      fill_q       <= 2'd0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          mfva_pkg::CFG_DRUM_CHANNEL:   drum_ch_q    <= cfg_data_i[3:0];
          mfva_pkg::CFG_DRUM_KEY_LOW:   drum_lo_q    <= cfg_data_i;
          mfva_pkg::CFG_DRUM_KEY_HIGH:  drum_hi_q    <= cfg_data_i;
          mfva_pkg::CFG_DRUM_PITCH_KEY: drum_pitch_q <= cfg_data_i;
          default: ;
        endcase
      end
      cnt_q  <= cnt_d;
      fill_q <= fill_d;
      if (acc) wr_q <= !wr_q;
      if (op_pop_i && op_valid_o) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) q_q[wr_q] <= op_new;
  end

endmodule

// File: design/mfva_back.sv
// Back end: voice state, serial voice scan sequencer, write shadowing, result queue.
// Depends on mfva_pkg.
module mfva_back #(
  parameter int VOICE_COUNT = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   op_valid_i,
  input  mfva_pkg::op_t          op_i,
  output logic                   op_pop_o,
  input  logic                   pop,
  output logic                   empty,
  output logic [7:0]             reg_index_o,
  output logic [7:0]             reg_value_o,
  output logic                   last_o,
  output mfva_pkg::back_status_t status_o
);

  localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [IW-1:0] LAST_V = IW'(VOICE_COUNT - 1);

  logic [6:0]  vkey_q [VOICE_COUNT], vkey_d [VOICE_COUNT];
  logic [3:0]  vch_q  [VOICE_COUNT], vch_d  [VOICE_COUNT];
  logic [31:0] vage_q [VOICE_COUNT], vage_d [VOICE_COUNT];
  logic        vact_q [VOICE_COUNT], vact_d [VOICE_COUNT];
  logic [7:0]  lo_q   [VOICE_COUNT], lo_d   [VOICE_COUNT];
  logic [7:0]  hi_q   [VOICE_COUNT], hi_d   [VOICE_COUNT];

  mfva_pkg::seq_state_e st_q, st_d;
  mfva_pkg::op_t op_q, op_d;
  logic [IW-1:0] idx_q, idx_d, match_idx_q, match_idx_d, best_q, best_d, sel_q, sel_d;
  logic          match_v_q, match_v_d, best_act_q, best_act_d;
  logic [31:0]   best_age_q, best_age_d;
  logic          pend_v_q, pend_v_d;
  logic [7:0]    pend_idx_q, pend_idx_d, pend_val_q, pend_val_d;

  mfva_pkg::wr_t oq_q [mfva_pkg::OQ_DEPTH];
  logic [1:0]    ow_q, or_q;
  logic [2:0]    oc_q;
  logic          ofull, opush;
  mfva_pkg::wr_t oq_in;

  logic          em, can_emit, go, hit, last_i;
  logic [7:0]    em_idx, em_val, nv, lo_new, hi_new;
  logic [9:0]    fnum;
  logic [IW-1:0] v;

  assign ofull    = (oc_q == 3'(mfva_pkg::OQ_DEPTH));
  assign empty    = (oc_q == 3'd0);
  assign reg_index_o = oq_q[or_q].idx;
  assign reg_value_o = oq_q[or_q].val;
  assign last_o      = oq_q[or_q].last;
  assign can_emit = !pend_v_q || !ofull;
  assign status_o.stall  = em && !can_emit;
  assign status_o.ocount = oc_q;

  always_comb begin
    vkey_d = vkey_q; vch_d = vch_q; vage_d = vage_q; vact_d = vact_q;
    lo_d = lo_q; hi_d = hi_q;
    st_d = st_q; op_d = op_q; idx_d = idx_q;
    match_idx_d = match_idx_q; match_v_d = match_v_q;
    best_d = best_q; best_act_d = best_act_q; best_age_d = best_age_q;
    sel_d = sel_q;
    pend_v_d = pend_v_q; pend_idx_d = pend_idx_q; pend_val_d = pend_val_q;
    op_pop_o = 1'b0;
    opush = 1'b0;
    oq_in = '0;
    em = 1'b0; em_idx = '0; em_val = '0;
    hit = (vch_q[idx_q] == op_q.ch) && (vkey_q[idx_q] == op_q.key);
    last_i = (idx_q == LAST_V);
    nv = hi_q[idx_q] & ~mfva_pkg::KEY_ON_BIT;
    fnum = mfva_pkg::key_fnum(op_q.pitch);
    lo_new = fnum[7:0];
    hi_new = (hi_q[sel_q] & ~mfva_pkg::HIGH_MASK) |
             {2'b00, 1'b1, mfva_pkg::key_block(op_q.pitch), fnum[9:8]};
    v = match_v_q ? match_idx_q : best_q;
    go = 1'b1;

    unique case (st_q)
      mfva_pkg::S_IDLE: begin
        if (op_valid_i) begin
          op_pop_o = 1'b1;
          op_d = op_i;
          idx_d = '0;
          match_v_d = 1'b0;
          st_d = (op_i.kind == mfva_pkg::OP_NONE) ? mfva_pkg::S_IDLE : mfva_pkg::S_SCAN;
        end
      end
      mfva_pkg::S_SCAN: begin
        unique case (op_q.kind)
          mfva_pkg::OP_ON: begin
            if (hit && !match_v_q) begin
              match_v_d = 1'b1;
              match_idx_d = idx_q;
            end
            priority if (idx_q == '0 ||
                         (best_act_q && !vact_q[idx_q]) ||
                         ((best_act_q == vact_q[idx_q]) && (best_age_q > vage_q[idx_q]))) begin
              best_d = idx_q;
              best_act_d = vact_q[idx_q];
              best_age_d = vage_q[idx_q];
            end else begin
            end
            if (last_i) st_d = mfva_pkg::S_APPLY;
            else idx_d = idx_q + IW'(1);
          end
          mfva_pkg::OP_REL, mfva_pkg::OP_OFF: begin
            if (hit && (vact_q[idx_q] || op_q.kind == mfva_pkg::OP_OFF)) begin
              if (nv != hi_q[idx_q]) begin
                em = 1'b1;
                em_idx = mfva_pkg::REG_FHIGH + 8'(idx_q);
                em_val = nv;
              end
            end
            go = !em || can_emit;
            if (go) begin
              if (hit && (vact_q[idx_q] || op_q.kind == mfva_pkg::OP_OFF)) begin
                hi_d[idx_q] = nv;
                vact_d[idx_q] = 1'b0;
              end
              if (last_i || (hit && vact_q[idx_q] && op_q.kind == mfva_pkg::OP_REL))
                st_d = mfva_pkg::S_FLUSH;
              else
                idx_d = idx_q + IW'(1);
            end
          end
          default: st_d = mfva_pkg::S_FLUSH;
        endcase
      end
      mfva_pkg::S_APPLY: begin
        vage_d[v] = op_q.age;
        vkey_d[v] = op_q.key;
        vch_d[v]  = op_q.ch;
        vact_d[v] = 1'b1;
        sel_d = v;
        st_d = op_q.sound ? mfva_pkg::S_EMIT_LO : mfva_pkg::S_FLUSH;
      end
      mfva_pkg::S_EMIT_LO: begin
        if (lo_new != lo_q[sel_q]) begin
          em = 1'b1;
          em_idx = mfva_pkg::REG_FLOW + 8'(sel_q);
          em_val = lo_new;
        end
        go = !em || can_emit;
        if (go) begin
          lo_d[sel_q] = lo_new;
          st_d = mfva_pkg::S_EMIT_HI;
        end
      end
      mfva_pkg::S_EMIT_HI: begin
        if (hi_new != hi_q[sel_q]) begin
          em = 1'b1;
          em_idx = mfva_pkg::REG_FHIGH + 8'(sel_q);
          em_val = hi_new;
        end
        go = !em || can_emit;
        if (go) begin
          hi_d[sel_q] = hi_new;
          st_d = mfva_pkg::S_FLUSH;
        end
      end
      mfva_pkg::S_FLUSH: begin
        if (!pend_v_q) begin
          st_d = mfva_pkg::S_IDLE;
        end else if (!ofull) begin
          opush = 1'b1;
          oq_in = '{idx: pend_idx_q, val: pend_val_q, last: 1'b1};
          pend_v_d = 1'b0;
          st_d = mfva_pkg::S_IDLE;
        end
      end
      default: st_d = mfva_pkg::S_IDLE;
    endcase

    if (em && can_emit) begin
      if (pend_v_q) begin
        opush = 1'b1;
        oq_in = '{idx: pend_idx_q, val: pend_val_q, last: 1'b0};
      end
      pend_v_d = 1'b1;
      pend_idx_d = em_idx;
      pend_val_d = em_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        vkey_q[i] <= '0; vch_q[i] <= '0; vage_q[i] <= '0; vact_q[i] <= 1'b0;
        lo_q[i] <= '0; hi_q[i] <= '0;
      end
      st_q <= mfva_pkg::S_IDLE;
      pend_v_q <= 1'b0;
      ow_q <= '0;
      or_q <= '0;
      oc_q <= '0;
    end else begin
      vkey_q <= vkey_d; vch_q <= vch_d; vage_q <= vage_d; vact_q <= vact_d;
      lo_q <= lo_d; hi_q <= hi_d;
      st_q <= st_d;
      pend_v_q <= pend_v_d;
      if (opush) ow_q <= ow_q + 2'd1;
      if (pop && !empty) or_q <= or_q + 2'd1;
      oc_q <= oc_q + {2'b00, opush} - {2'b00, pop && !empty};
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    idx_q <= idx_d;
    match_idx_q <= match_idx_d;
    match_v_q <= match_v_d;
    best_q <= best_d;
    best_act_q <= best_act_d;
    best_age_q <= best_age_d;
    sel_q <= sel_d;
    pend_idx_q <= pend_idx_d;
    pend_val_q <= pend_val_d;
    if (opush) oq_q[ow_q] <= oq_in;
  end

endmodule
